### rtl/core/tmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmi_pkg
// Command codes, event codes, request opcodes, state codes and the character decoder shared by the interpreter.
// ----------------------------------------------------------------------------
package tmi_pkg;

   typedef logic [2:0] cmd_type;
   typedef logic [3:0] event_type;
   typedef logic [2:0] op_type;

   localparam cmd_type CMD_RIGHT = 3'd0;
   localparam cmd_type CMD_LEFT  = 3'd1;
   localparam cmd_type CMD_INC   = 3'd2;
   localparam cmd_type CMD_DEC   = 3'd3;
   localparam cmd_type CMD_OUT   = 3'd4;
   localparam cmd_type CMD_IN    = 3'd5;
   localparam cmd_type CMD_OPEN  = 3'd6;
   localparam cmd_type CMD_CLOSE = 3'd7;

   localparam event_type EV_OK         = 4'd0;
   localparam event_type EV_OUTPUT     = 4'd1;
   localparam event_type EV_NEED_INPUT = 4'd2;
   localparam event_type EV_HALTED     = 4'd3;
   localparam event_type EV_BUDGET     = 4'd4;
   localparam event_type EV_RIGHT_EDGE = 4'd5;
   localparam event_type EV_LEFT_EDGE  = 4'd6;
   localparam event_type EV_UNM_CLOSE  = 4'd7;
   localparam event_type EV_UNM_OPEN   = 4'd8;
   localparam event_type EV_FULL       = 4'd9;

   localparam op_type OP_LOAD    = 3'd0;
   localparam op_type OP_RUN     = 3'd1;
   localparam op_type OP_SUPPLY  = 3'd2;
   localparam op_type OP_RESTART = 3'd3;
   localparam op_type OP_CLEAR   = 3'd4;

   localparam logic [1:0] ST_READY  = 2'd0;
   localparam logic [1:0] ST_AWAIT  = 2'd1;
   localparam logic [1:0] ST_HALTED = 2'd2;
   localparam logic [1:0] ST_FAULT  = 2'd3;

   // Character to command; valid flag low for every other character.
   function automatic logic [3:0] decode_char(input logic [7:0] c);
      logic [3:0] r;
      case (c)
         8'h3E:   r = {1'b1, CMD_RIGHT};
         8'h3C:   r = {1'b1, CMD_LEFT};
         8'h2B:   r = {1'b1, CMD_INC};
         8'h2D:   r = {1'b1, CMD_DEC};
         8'h2E:   r = {1'b1, CMD_OUT};
         8'h2C:   r = {1'b1, CMD_IN};
         8'h5B:   r = {1'b1, CMD_OPEN};
         8'h5D:   r = {1'b1, CMD_CLOSE};
         default: r = 4'd0;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/tape_machine_interpreter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_machine_interpreter
// Eight-command byte-tape machine with on-the-fly bracket matching.
// ----------------------------------------------------------------------------
//  channel   ports                           direction
//  request   start, busy, req_op, req_data_byte   in (busy out)
//  response  rsp_valid, rsp_event_res, rsp_out_byte,
//            rsp_command_position, rsp_data_position   out
//  config    csr_we, csr_step_budget         in
//
//  A load sends a dropped or rejected character straight to the response;
//  an accepted one reads the bracket stack, then writes the stores. A run
//  executes each command as a fetch of program/match entry, a tape cell read,
//  then execute through the one shared ALU step; the commands per run are
//  bounded by step_budget. Restart sweeps the tape, one cell per cycle. Reset
//  runs the same sweep (busy high) before the first transfer.
//  The receiver cannot stall: each response is a one-cycle strobe.
module tape_machine_interpreter #(
   parameter int TAPE_DEPTH    = 4096,
   parameter int PROGRAM_DEPTH = 4096,
   parameter int STACK_DEPTH   = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tmi_pkg::op_type       req_op,
   input  logic [7:0]            req_data_byte,
   input  logic                  csr_we,
   input  logic [23:0]           csr_step_budget,
   output logic                  rsp_valid,
   output logic [3:0]            rsp_event_res,
   output logic [7:0]            rsp_out_byte,
   output logic [12:0]           rsp_command_position,
   output logic [11:0]           rsp_data_position
);
   import tmi_pkg::*;

   localparam int PW = $clog2(PROGRAM_DEPTH);
   localparam int PL = $clog2(PROGRAM_DEPTH + 1);
   localparam int TW = $clog2(TAPE_DEPTH);
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SC = $clog2(STACK_DEPTH + 1);

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_LPOP   = 4'd2;
   localparam logic [3:0] S_LWR    = 4'd3;
   localparam logic [3:0] S_FETCH  = 4'd4;
   localparam logic [3:0] S_TREAD  = 4'd5;
   localparam logic [3:0] S_EXEC   = 4'd6;
   localparam logic [3:0] S_RESP   = 4'd7;

   // Memories.
   logic [2:0]    prog_mem  [PROGRAM_DEPTH];
   logic [PL-1:0] match_mem [PROGRAM_DEPTH];
   logic [PL-1:0] stack_mem [STACK_DEPTH];
   logic [7:0]    tape_mem  [TAPE_DEPTH];

   logic [3:0]    state_ff, state_in;
   logic [23:0]   budget_ff;
   logic [PL-1:0] plen_ff, plen_in;
   logic [SC-1:0] scnt_ff, scnt_in;
   logic [PL-1:0] cp_ff, cp_in;
   logic [TW:0]   dp_ff, dp_in;
   logic [1:0]    rs_ff, rs_in;
   logic [TW:0]   clr_ff, clr_in;
   logic [23:0]   steps_ff, steps_in;
   logic [2:0]    cmd_ff;
   logic [PL-1:0] mt_ff;
   logic [PL-1:0] stk_ff;
   logic [7:0]    cell_ff;
   logic [2:0]    ldcmd_ff, ldcmd_in;
   logic [3:0]    ev_ff, ev_in;
   logic [7:0]    ob_ff, ob_in;
   logic          rv_ff, rv_in;

   // Memory write controls.
   logic          tw_en;  logic [TW-1:0] tw_a;  logic [7:0] tw_d;
   logic          pw_en;
   logic          mw1_en; logic [PW-1:0] mw1_a; logic [PL-1:0] mw1_d;
   logic          mw2_en;
   logic          sw_en;

   logic [23:0]   budget_eff;
   logic [3:0]    dec;
   logic [7:0]    alu;

   assign budget_eff = (budget_ff == 24'd0) ? 24'd1 : budget_ff;
   assign dec        = decode_char(req_data_byte);
   assign busy       = (state_ff != S_IDLE);

   // Read ports, registered.
   always_ff @(posedge clock) begin
      cmd_ff  <= prog_mem[cp_ff[PW-1:0]];
      mt_ff   <= match_mem[cp_ff[PW-1:0]];
      cell_ff <= tape_mem[dp_ff[TW-1:0]];
      stk_ff  <= stack_mem[SW'(scnt_ff - SC'(1))];
      if (tw_en) tape_mem[tw_a] <= tw_d;
      if (pw_en) prog_mem[plen_ff[PW-1:0]] <= ldcmd_ff;
      if (mw1_en) match_mem[mw1_a] <= mw1_d;
      if (mw2_en) match_mem[plen_ff[PW-1:0]] <= stk_ff;
      if (sw_en) stack_mem[scnt_ff[SW-1:0]] <= plen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         budget_ff <= 24'd65536;
         plen_ff   <= '0;
         scnt_ff   <= '0;
         cp_ff     <= '0;
         dp_ff     <= '0;
         rs_ff     <= ST_READY;
         clr_ff    <= '0;
         rv_ff     <= 1'b0;
         steps_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) budget_ff <= csr_step_budget;
         plen_ff  <= plen_in;
         scnt_ff  <= scnt_in;
         cp_ff    <= cp_in;
         dp_ff    <= dp_in;
         rs_ff    <= rs_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
         steps_ff <= steps_in;
      end
      ldcmd_ff <= ldcmd_in;
      ev_ff    <= ev_in;
      ob_ff    <= ob_in;
   end

   always_comb begin
      state_in = state_ff; plen_in = plen_ff; scnt_in = scnt_ff;
      cp_in = cp_ff; dp_in = dp_ff; rs_in = rs_ff; clr_in = clr_ff;
      steps_in = steps_ff; ldcmd_in = ldcmd_ff; ev_in = ev_ff; ob_in = ob_ff;
      rv_in = 1'b0;
      tw_en = 1'b0; tw_a = clr_ff[TW-1:0]; tw_d = 8'd0;
      pw_en = 1'b0; mw1_en = 1'b0; mw1_a = stk_ff[PW-1:0]; mw1_d = plen_ff;
      mw2_en = 1'b0; sw_en = 1'b0;
      // Shared ALU: cell +1 / -1.
      alu = (cmd_ff == CMD_DEC) ? (cell_ff - 8'd1) : (cell_ff + 8'd1);
      case (state_ff)
         S_CLR: begin
            // Sweep the tape clear, one cell a cycle.
            tw_en = 1'b1;
            if (clr_ff == (TW+1)'(TAPE_DEPTH - 1)) begin
               clr_in = '0;
               state_in = S_RESP;
               rv_in = 1'b0;
               ev_in = EV_OK; ob_in = 8'd0;
               state_in = (rs_ff == ST_READY && dp_ff == '0 && steps_ff == 24'd1)
                          ? S_RESP : S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (start) begin
               ev_in = EV_OK; ob_in = 8'd0; steps_in = 24'd0;
               case (req_op)
                  OP_LOAD: begin
                     ldcmd_in = dec[2:0];
                     if (!dec[3]) begin
                        state_in = S_RESP;
                     end else if (plen_ff >= PL'(PROGRAM_DEPTH)) begin
                        ev_in = EV_FULL; state_in = S_RESP;
                     end else if (dec[2:0] == CMD_OPEN &&
                                  scnt_ff >= SC'(STACK_DEPTH)) begin
                        ev_in = EV_FULL; state_in = S_RESP;
                     end else if (dec[2:0] == CMD_CLOSE && scnt_ff == '0) begin
                        ev_in = EV_UNM_CLOSE; state_in = S_RESP;
                     end else begin
                        state_in = S_LPOP;
                     end
                  end
                  OP_RUN, OP_SUPPLY: begin
                     if (scnt_ff != '0) begin
                        rs_in = ST_FAULT; ev_in = EV_UNM_OPEN; state_in = S_RESP;
                     end else begin
                        if (req_op == OP_SUPPLY && rs_ff == ST_AWAIT &&
                            cp_ff < plen_ff) begin
                           tw_en = 1'b1; tw_a = dp_ff[TW-1:0]; tw_d = req_data_byte;
                           cp_in = cp_ff + 1'b1;
                           steps_in = 24'd1;
                        end
                        state_in = S_FETCH;
                     end
                  end
                  OP_RESTART: begin
                     dp_in = '0; cp_in = '0; rs_in = ST_READY;
                     clr_in = '0; steps_in = 24'd1;
                     state_in = S_CLR;
                  end
                  OP_CLEAR: begin
                     plen_in = '0; scnt_in = '0; cp_in = '0; rs_in = ST_READY;
                     state_in = S_RESP;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_LPOP: begin
            // stk_ff now holds the top of stack.
            state_in = S_LWR;
         end
         S_LWR: begin
            pw_en = 1'b1;
            if (ldcmd_ff == CMD_OPEN) begin
               sw_en = 1'b1; scnt_in = scnt_ff + 1'b1;
            end else if (ldcmd_ff == CMD_CLOSE) begin
               mw1_en = 1'b1; mw2_en = 1'b1; scnt_in = scnt_ff - 1'b1;
            end
            plen_in = plen_ff + 1'b1;
            state_in = S_RESP;
         end
         S_FETCH: begin
            if (cp_ff >= plen_ff) begin
               rs_in = ST_HALTED; ev_in = EV_HALTED; state_in = S_RESP;
            end else if (steps_ff >= budget_eff) begin
               rs_in = ST_READY; ev_in = EV_BUDGET; state_in = S_RESP;
            end else begin
               state_in = S_TREAD;
            end
         end
         S_TREAD: state_in = S_EXEC;
         S_EXEC: begin
            state_in = S_FETCH;
            steps_in = steps_ff + 24'd1;
            cp_in = cp_ff + 1'b1;
            case (cmd_ff)
               CMD_RIGHT: begin
                  if (dp_ff >= (TW+1)'(TAPE_DEPTH - 1)) begin
                     rs_in = ST_FAULT; ev_in = EV_RIGHT_EDGE;
                     cp_in = cp_ff; state_in = S_RESP;
                  end else dp_in = dp_ff + 1'b1;
               end
               CMD_LEFT: begin
                  if (dp_ff == '0) begin
                     rs_in = ST_FAULT; ev_in = EV_LEFT_EDGE;
                     cp_in = cp_ff; state_in = S_RESP;
                  end else dp_in = dp_ff - 1'b1;
               end
               CMD_INC, CMD_DEC: begin
                  tw_en = 1'b1; tw_a = dp_ff[TW-1:0]; tw_d = alu;
               end
               CMD_OUT: begin
                  ob_in = cell_ff; ev_in = EV_OUTPUT; rs_in = ST_READY;
                  state_in = S_RESP;
               end
               CMD_IN: begin
                  rs_in = ST_AWAIT; ev_in = EV_NEED_INPUT;
                  cp_in = cp_ff; state_in = S_RESP;
               end
               CMD_OPEN: if (cell_ff == 8'd0) cp_in = mt_ff + 1'b1;
               default:  if (cell_ff != 8'd0) cp_in = mt_ff + 1'b1;
            endcase
         end
         S_RESP: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid            = rv_ff;
   assign rsp_event_res        = ev_ff;
   assign rsp_out_byte         = ob_ff;
   assign rsp_command_position = 13'(cp_ff);
   assign rsp_data_position    = 12'(dp_ff);

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rv_ff |=> !rv_ff) else $error("back-to-back response");
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      scnt_ff <= SC'(STACK_DEPTH)) else $error("stack count overflow");
   a_cp_bound: assert property (@(posedge clock) disable iff (reset)
      cp_ff <= plen_ff || scnt_ff != '0 || state_ff == S_IDLE)
      else $error("command pointer past program");
   a_dp_bound: assert property (@(posedge clock) disable iff (reset)
      dp_ff < (TW+1)'(TAPE_DEPTH)) else $error("data pointer out of range");

endmodule

### test/tb_tape_machine_interpreter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tape_machine_interpreter
// Self-checking bench for the tape machine interpreter. A driver pulls
// requests from a pending queue and feeds a cycle-free model of the machine
// at each transfer. A monitor compares each response strobe with the oldest
// predicted result. The run covers directed edge cases, bracket-stack
// overflow, tape edges, and random programs, some with unmatched brackets,
// under several step budgets.
// ----------------------------------------------------------------------------
module tb_tape_machine_interpreter;
   import tmi_pkg::*;

   localparam int TAPE_N  = 4096;
   localparam int PROG_N  = 4096;
   localparam int STACK_N = 256;
   localparam int WATCHDOG_LIMIT = 200000;

   // Opcodes with no function; the block answers them with a plain ok
   localparam op_type OP_SPARE_LO = 3'd5;
   localparam op_type OP_SPARE_HI = 3'd7;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } request_type;

   typedef struct packed {
      event_type   ev;
      logic [7:0]  ob;
      logic [12:0] cp;
      logic [11:0] dp;
   } tape_result_type;

   // DUT connections; every input known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   op_type      req_op = OP_LOAD;
   logic [7:0]  req_data_byte = 8'd0;
   logic        csr_we = 1'b0;
   logic [23:0] csr_step_budget = 24'd0;
   logic        rsp_valid;
   logic [3:0]  rsp_event_res;
   logic [7:0]  rsp_out_byte;
   logic [12:0] rsp_command_position;
   logic [11:0] rsp_data_position;

   tape_machine_interpreter uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_data_byte(req_data_byte),
      .csr_we(csr_we), .csr_step_budget(csr_step_budget),
      .rsp_valid(rsp_valid), .rsp_event_res(rsp_event_res),
      .rsp_out_byte(rsp_out_byte),
      .rsp_command_position(rsp_command_position),
      .rsp_data_position(rsp_data_position)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Queues between the stimulus, the driver and the monitor
   request_type     pending_requests[$];
   tape_result_type expected_results[$];
   int              error_count = 0;
   int              counted_items = 0;
   bit              quiet = 1'b0;     // no idling at all when set
   bit              burst_on = 1'b1;  // idle bursts allowed in this stretch
   int              gap = 0;
   int              idle_cycles = 0;

   // ------------------------------------------------------------------------
   // Machine model: program store, jump table, bracket stack, tape, pointers
   // ------------------------------------------------------------------------
   cmd_type     prog_mem[PROG_N];
   int          jump_mem[PROG_N];
   int          open_stack[STACK_N];
   logic [7:0]  tape_mem[TAPE_N];
   int          stack_depth = 0;
   int          prog_len = 0;
   int          cmd_ptr = 0;
   int          data_ptr = 0;
   logic [1:0]  machine_state = ST_READY;
   logic [23:0] step_budget = 24'd65536;

   initial begin
      foreach (tape_mem[i]) tape_mem[i] = 8'd0;
   end

   function automatic bit char_to_cmd(input logic [7:0] c, output cmd_type code);
      code = CMD_RIGHT;
      case (c)
         ">": code = CMD_RIGHT;
         "<": code = CMD_LEFT;
         "+": code = CMD_INC;
         "-": code = CMD_DEC;
         ".": code = CMD_OUT;
         ",": code = CMD_IN;
         "[": code = CMD_OPEN;
         "]": code = CMD_CLOSE;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // Append one program character, matching brackets on the fly
   function automatic event_type append_char(input logic [7:0] c);
      cmd_type code;
      int      partner;
      if (!char_to_cmd(c, code)) return EV_OK;
      if (prog_len >= PROG_N) return EV_FULL;
      if (code == CMD_OPEN) begin
         if (stack_depth >= STACK_N) return EV_FULL;
         open_stack[stack_depth] = prog_len;
         stack_depth++;
      end else if (code == CMD_CLOSE) begin
         if (stack_depth == 0) return EV_UNM_CLOSE;
         stack_depth--;
         partner = open_stack[stack_depth];
         jump_mem[partner] = prog_len;
         jump_mem[prog_len] = partner;
      end
      prog_mem[prog_len] = code;
      prog_len++;
      return EV_OK;
   endfunction

   // Execute until output, input wait, end, fault or budget exhaustion
   function automatic event_type execute(input bit supply, input logic [7:0] b,
                                         output logic [7:0] ob);
      int limit;
      int steps;
      int c;
      limit = (step_budget == 0) ? 1 : int'(step_budget);
      steps = 0;
      ob = 8'd0;
      if (stack_depth != 0) begin
         machine_state = ST_FAULT;
         return EV_UNM_OPEN;
      end
      if (supply && machine_state == ST_AWAIT && cmd_ptr < prog_len) begin
         tape_mem[data_ptr] = b;
         cmd_ptr++;
         steps = 1;
      end
      while (1) begin
         c = cmd_ptr;
         if (c >= prog_len) begin
            machine_state = ST_HALTED;
            return EV_HALTED;
         end
         if (steps >= limit) begin
            machine_state = ST_READY;
            return EV_BUDGET;
         end
         case (prog_mem[c])
            CMD_RIGHT: begin
               if (data_ptr >= TAPE_N - 1) begin
                  machine_state = ST_FAULT;
                  return EV_RIGHT_EDGE;
               end
               data_ptr++;
            end
            CMD_LEFT: begin
               if (data_ptr == 0) begin
                  machine_state = ST_FAULT;
                  return EV_LEFT_EDGE;
               end
               data_ptr--;
            end
            CMD_INC: tape_mem[data_ptr] = tape_mem[data_ptr] + 8'd1;
            CMD_DEC: tape_mem[data_ptr] = tape_mem[data_ptr] - 8'd1;
            CMD_OUT: begin
               ob = tape_mem[data_ptr];
               cmd_ptr = c + 1;
               machine_state = ST_READY;
               return EV_OUTPUT;
            end
            CMD_IN: begin
               machine_state = ST_AWAIT;
               return EV_NEED_INPUT;
            end
            CMD_OPEN: if (tape_mem[data_ptr] == 8'd0) c = jump_mem[c];
            default:  if (tape_mem[data_ptr] != 8'd0) c = jump_mem[c];
         endcase
         cmd_ptr = c + 1;
         steps++;
      end
   endfunction

   function automatic tape_result_type apply_request(input request_type rq);
      tape_result_type r;
      logic [7:0]      ob;
      r = '0;
      ob = 8'd0;
      case (rq.op)
         OP_LOAD:   r.ev = append_char(rq.data);
         OP_RUN:    r.ev = execute(1'b0, rq.data, ob);
         OP_SUPPLY: r.ev = execute(1'b1, rq.data, ob);
         OP_RESTART: begin
            foreach (tape_mem[i]) tape_mem[i] = 8'd0;
            data_ptr = 0;
            cmd_ptr = 0;
            machine_state = ST_READY;
            r.ev = EV_OK;
         end
         OP_CLEAR: begin
            prog_len = 0;
            stack_depth = 0;
            cmd_ptr = 0;
            machine_state = ST_READY;
            r.ev = EV_OK;
         end
         default: r.ev = EV_OK;
      endcase
      r.ob = ob;
      r.cp = cmd_ptr[12:0];
      r.dp = data_ptr[11:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: one nonblocking write of start per edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive
      request_type nxt;
      logic        go;
      if (reset) begin
         start <= 1'b0;
         gap = 0;
      end else begin
         go = start;
         if (start && !busy) begin
            // Transfer taken: predict it, then maybe open an idle burst
            expected_results.push_back(
               apply_request(request_type'{req_op, req_data_byte}));
            go = 1'b0;
            if (!quiet && burst_on && $urandom_range(0, 3) == 0)
               gap = $urandom_range(1, 14);
            if (!quiet && $urandom_range(0, 40) == 0) burst_on = !burst_on;
         end
         if (!go) begin
            if (gap > 0) begin
               gap--;
            end else if (pending_requests.size() > 0) begin
               nxt = pending_requests.pop_front();
               req_op <= nxt.op;
               req_data_byte <= nxt.data;
               go = 1'b1;
            end
         end
         start <= go;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor and watchdog
   // ------------------------------------------------------------------------
   task automatic report(input string what, input int got, input int want);
      $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : watch
      tape_result_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               report("unexpected response, event", rsp_event_res, -1);
            end else begin
               want = expected_results.pop_front();
               if (rsp_event_res != want.ev) report("event", rsp_event_res, want.ev);
               if (rsp_out_byte != want.ob) report("out byte", rsp_out_byte, want.ob);
               if (rsp_command_position != want.cp)
                  report("command position", rsp_command_position, want.cp);
               if (rsp_data_position != want.dp)
                  report("data position", rsp_data_position, want.dp);
            end
         end
         if (rsp_valid || (start && !busy)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic add(input op_type op, input logic [7:0] data);
      pending_requests.push_back(request_type'{op, data});
      counted_items++;
   endtask

   task automatic load_text(input string s);
      foreach (s[i]) add(OP_LOAD, s[i]);
   endtask

   // Hold until every transfer is answered and the block is idle again
   task automatic drain();
      do @(negedge clock);
      while (pending_requests.size() != 0 || start || expected_results.size() != 0 || busy);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_budget(input logic [23:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_step_budget <= v;
      step_budget = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // One episode: program with random content, usually after a clear, then a burst of runs and other requests
   task automatic random_episode();
      int         len;
      int         depth;
      int         runs;
      bit         broken;
      logic [7:0] c;
      if ($urandom_range(0, 24) == 0) add(OP_RESTART, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) != 0) add(OP_CLEAR, 8'($urandom_range(0, 255)));
      broken = ($urandom_range(0, 9) == 0);
      len = $urandom_range(2, 24);
      depth = 0;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 10))
            0: c = ">";
            1: c = "<";
            2, 3: c = "+";
            4: c = "-";
            5: c = ".";
            6: c = ",";
            7: begin c = "["; depth++; end
            8: begin
               if (depth > 0 || broken) c = "]";
               else c = "+";
               if (depth > 0) depth--;
            end
            9: c = ">";
            default: c = 8'($urandom_range(0, 255));  // mostly noise, dropped
         endcase
         add(OP_LOAD, c);
      end
      // close what is still open unless this episode is meant to be broken
      if (!broken) while (depth > 0) begin add(OP_LOAD, "]"); depth--; end
      runs = $urandom_range(2, 8);
      for (int i = 0; i < runs; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: add(OP_RUN, 8'($urandom_range(0, 255)));
            4, 5, 6: add(OP_SUPPLY, 8'($urandom_range(0, 255)));
            7: add(OP_LOAD, 8'($urandom_range(0, 255)));
            8: add(op_type'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                   8'($urandom_range(0, 255)));
            default: add(OP_SUPPLY, 8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   task automatic random_phase(input int target);
      int stop_at;
      stop_at = counted_items + target;
      while (counted_items < stop_at) random_episode();
      drain();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: noise, empty program, stray close, pending open
      add(OP_LOAD, "a");
      add(OP_RUN, 8'h00);
      add(OP_LOAD, "]");
      add(OP_LOAD, "[");
      add(OP_RUN, 8'hFF);
      add(OP_CLEAR, 8'h00);
      // input wait, supply, output of the supplied byte, left edge
      load_text(",.+<");
      add(OP_RUN, 8'h00);
      add(OP_SUPPLY, 8'hFF);
      add(OP_RUN, 8'h00);
      add(OP_RUN, 8'h00);
      add(OP_SPARE_LO, 8'hA5);
      add(OP_SPARE_HI, 8'h5A);
      add(OP_SUPPLY, 8'h12);          // not waiting: byte ignored
      add(OP_RESTART, 8'h00);
      add(OP_RUN, 8'h00);
      add(OP_RUN, 8'h00);             // still parked on the input command
      add(OP_CLEAR, 8'h00);
      load_text("-[+]");
      add(OP_RUN, 8'h00);
      add(OP_LOAD, ".");              // extend after halt, then continue
      add(OP_RUN, 8'h00);
      drain();

      set_budget(24'd1);
      random_phase(320);

      // Widest budget: walk right until the tape edge
      set_budget(24'hFFFFFF);
      add(OP_RESTART, 8'h00);
      add(OP_CLEAR, 8'h00);
      load_text("+[>+]");
      add(OP_RUN, 8'h00);
      add(OP_RUN, 8'h00);
      add(OP_RESTART, 8'h00);
      // Bracket stack overflow
      add(OP_CLEAR, 8'h00);
      for (int i = 0; i <= STACK_N; i++) add(OP_LOAD, "[");
      add(OP_RUN, 8'h00);
      add(OP_CLEAR, 8'h00);
      drain();

      // Stray close and noise, then a budget-limited run
      set_budget(24'd5);
      for (int i = 0; i < 40; i++) add(OP_LOAD, "+");
      add(OP_LOAD, "]");
      add(OP_LOAD, "x");
      add(OP_RUN, 8'h00);
      add(OP_CLEAR, 8'h00);
      drain();

      set_budget(24'd3);
      random_phase(320);
      set_budget(24'd40);
      random_phase(320);
      set_budget(24'd250);
      random_phase(320);
      set_budget(24'd600);
      quiet = 1'b1;
      random_phase(320);

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
